// ===== src/bgma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgma_pkg
// Types, constants and state codes of the battery gauge.
// ----------------------------------------------------------------------------
package bgma_pkg;

  localparam int DEFAULT_WINDOW_DEPTH = 8;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 7;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_BY_PIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VBUS_ACTIVE_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL_LIMIT   = 2'd3;

  // Register reset values.
  localparam logic        RST_DETECT_BY_PIN     = 1'b1;
  localparam logic        RST_VBUS_ACTIVE_LEVEL = 1'b1;
  localparam logic [11:0] RST_SAMPLE_INTERVAL   = 12'd60;
  localparam logic [6:0]  RST_LOW_LEVEL_LIMIT   = 7'd20;

  // USB window and level curve.
  localparam logic [11:0] USB_LOW_BOUND  = 12'd1500;
  localparam logic [11:0] USB_HIGH_BOUND = 12'd4000;
  localparam logic [11:0] LEVEL_BASE     = 12'd1970;
  localparam logic [11:0] LEVEL_TOP      = 12'd2430;
  localparam logic [8:0]  LEVEL_SPAN     = 9'd92;
  localparam logic [6:0]  LEVEL_FULL     = 7'd100;

  // floor(x / 23) for x below 460 as (x * 713) >> 14.
  localparam logic [18:0] RECIP_23    = 19'd713;
  localparam int          RECIP_SHIFT = 14;

  typedef struct packed {
    logic [SAMPLE_W-1:0] battery_sample;
    logic [SAMPLE_W-1:0] usb_sample;
    logic                vbus_pin;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_percent;
    logic               charging_raw;
    logic               charging_shown;
    logic               discharging;
    logic               battery_low;
    logic               charge_changed;
    logic               low_changed;
    logic               sample_taken;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MAP_BAND,
    S_MAP_LEVEL,
    S_DELIVER
  } gauge_state_t;

endpackage

// ===== src/battery_gauge_moving_average.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_gauge_moving_average
// Moving-average battery percentage gauge with charge and low-battery events.
// ----------------------------------------------------------------------------
// Usage: each request on the in_ channel is one check tick carrying the
// battery and USB converter samples and the VBUS pin level. Every request
// produces exactly one result request on the out_ channel with the level,
// the charging and low flags and the change events of that tick.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while the
// block is idle; writes take effect at once.
// Sequence: a tick that takes no battery sample goes to the delivery step
// on acceptance. A tick that takes a sample passes a window RAM read, the
// sum update, a restoring divider (window_sum / fill count, SUM_W = 12 +
// clog2(WINDOW_DEPTH)) and two level mapping steps before delivery. One
// tick is in work at a time and the next is taken from the cycle in which
// the result is offered.
// The next tick may be accepted while a finished result still waits in the
// output register; a stalled receiver holds the result, and the following
// tick waits before delivery until the register frees.
// Reset (rst_n low, synchronous) empties the window, clears the level and
// flags and restores the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module battery_gauge_moving_average #(
  parameter int WINDOW_DEPTH = bgma_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bgma_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bgma_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [bgma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgma_pkg::CFG_W-1:0]    cfg_wdata
);

  import bgma_pkg::*;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W:0]   DEPTH_EXT = (SLOT_W + 1)'(WINDOW_DEPTH);

  // Configuration registers.
  logic        detect_by_pin_r;
  logic        vbus_level_r;
  logic [11:0] interval_r;
  logic [6:0]  low_limit_r;

  // Gauge state.
  gauge_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [SLOT_W-1:0]   oldest_r, oldest_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [11:0]         phase_r, phase_nxt;
  logic                chg_r, chg_nxt;
  logic                low_r, low_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;

  // Per-tick working registers.
  logic [SAMPLE_W-1:0] bat_r, bat_nxt;
  logic                chg_ev_r, chg_ev_nxt;
  logic                low_ev_r, low_ev_nxt;
  logic                taken_r, taken_nxt;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic [2:0]          band_r, band_nxt;
  logic [6:0]          rest_r, rest_nxt;
  logic                below_r, below_nxt;
  logic                above_r, above_nxt;

  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Datapath helpers.
  logic                detected;
  logic [11:0]         interval_eff;
  logic                window_full;
  logic [SLOT_W:0]     slot_sum;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W:0]     oldest_inc;
  logic [SAMPLE_W-1:0] old_sample;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_quo;
  logic                ram_we;
  logic [11:0]         off12;
  logic [8:0]          off;
  logic [8:0]          rest5;
  logic [18:0]         prod;
  logic [LEVEL_W-1:0]  level_map;
  logic                fresh_low;

  always_comb begin
    if (detect_by_pin_r) begin
      detected = (in_data.vbus_pin == vbus_level_r);
    end else begin
      detected = (in_data.usb_sample > USB_LOW_BOUND) &&
                 (in_data.usb_sample < USB_HIGH_BOUND);
    end
    interval_eff = (interval_r == 12'd0) ? 12'd1 : interval_r;
    window_full  = (fill_r == FULL_CNT);

    // While filling, the next free slot is oldest + fill wrapped once.
    slot_sum = (SLOT_W + 1)'(oldest_r) + (SLOT_W + 1)'(fill_r[SLOT_W-1:0]);
    if (window_full) begin
      slot = oldest_r;
    end else if (slot_sum >= DEPTH_EXT) begin
      slot = SLOT_W'(slot_sum - DEPTH_EXT);
    end else begin
      slot = slot_sum[SLOT_W-1:0];
    end
    oldest_inc = (SLOT_W + 1)'(oldest_r) + 1'b1;

    // Level curve: band of 92 counts each, then floor(5 * rest / 23).
    off12 = avg_r - LEVEL_BASE;
    off   = off12[8:0];
    rest5 = 9'({rest_r, 2'b00}) + 9'(rest_r);
    prod  = 19'(rest5) * RECIP_23;
    if (above_r) begin
      level_map = LEVEL_FULL;
    end else if (below_r) begin
      level_map = '0;
    end else begin
      level_map = 7'({band_r, 4'b0000}) + 7'({band_r, 2'b00}) +
                  7'(prod[RECIP_SHIFT+4:RECIP_SHIFT]);
    end
    fresh_low = (level_map <= low_limit_r);
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    sum_nxt       = sum_r;
    phase_nxt     = phase_r;
    chg_nxt       = chg_r;
    low_nxt       = low_r;
    level_nxt     = level_r;
    bat_nxt       = bat_r;
    chg_ev_nxt    = chg_ev_r;
    low_ev_nxt    = low_ev_r;
    taken_nxt     = taken_r;
    avg_nxt       = avg_r;
    band_nxt      = band_r;
    rest_nxt      = rest_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    div_start     = 1'b0;
    ram_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bat_nxt    = in_data.battery_sample;
          low_ev_nxt = 1'b0;
          chg_ev_nxt = 1'b0;
          taken_nxt  = 1'b1;
          state_nxt  = S_READ;
          if (detected != chg_r) begin
            chg_nxt    = detected;
            chg_ev_nxt = 1'b1;
          end else if (window_full) begin
            if ({1'b0, phase_r} + 13'd1 >= {1'b0, interval_eff}) begin
              phase_nxt = '0;
            end else begin
              phase_nxt = phase_r + 1'b1;
              taken_nxt = 1'b0;
              state_nxt = S_DELIVER;
            end
          end
        end
      end
      S_READ: begin
        // The RAM read of the slot lands during the next state.
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        ram_we = 1'b1;
        if (window_full) begin
          sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(bat_r);
          oldest_nxt = (oldest_inc == DEPTH_EXT) ? '0 : oldest_inc[SLOT_W-1:0];
        end else begin
          sum_nxt  = sum_r + SUM_W'(bat_r);
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          avg_nxt   = div_quo[SAMPLE_W-1:0];
          state_nxt = S_MAP_BAND;
        end
      end
      S_MAP_BAND: begin
        below_nxt = (avg_r < LEVEL_BASE);
        above_nxt = (avg_r >= LEVEL_TOP);
        if (off >= 4 * LEVEL_SPAN) begin
          band_nxt = 3'd4;
          rest_nxt = 7'(off - 4 * LEVEL_SPAN);
        end else if (off >= 3 * LEVEL_SPAN) begin
          band_nxt = 3'd3;
          rest_nxt = 7'(off - 3 * LEVEL_SPAN);
        end else if (off >= 2 * LEVEL_SPAN) begin
          band_nxt = 3'd2;
          rest_nxt = 7'(off - 2 * LEVEL_SPAN);
        end else if (off >= LEVEL_SPAN) begin
          band_nxt = 3'd1;
          rest_nxt = 7'(off - LEVEL_SPAN);
        end else begin
          band_nxt = 3'd0;
          rest_nxt = 7'(off);
        end
        state_nxt = S_MAP_LEVEL;
      end
      S_MAP_LEVEL: begin
        level_nxt = level_map;
        if (window_full) begin
          low_nxt    = fresh_low;
          low_ev_nxt = (fresh_low != low_r);
        end
        state_nxt = S_DELIVER;
      end
      S_DELIVER: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.level_percent   = level_r;
          out_data_nxt.charging_raw    = chg_r;
          out_data_nxt.charging_shown  = chg_r && (level_r != LEVEL_FULL);
          out_data_nxt.discharging     = ~chg_r;
          out_data_nxt.battery_low     = low_r;
          out_data_nxt.charge_changed  = chg_ev_r;
          out_data_nxt.low_changed     = low_ev_r;
          out_data_nxt.sample_taken    = taken_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      fill_r          <= '0;
      oldest_r        <= '0;
      sum_r           <= '0;
      phase_r         <= '0;
      chg_r           <= 1'b0;
      low_r           <= 1'b0;
      level_r         <= '0;
      out_valid_r     <= 1'b0;
      detect_by_pin_r <= RST_DETECT_BY_PIN;
      vbus_level_r    <= RST_VBUS_ACTIVE_LEVEL;
      interval_r      <= RST_SAMPLE_INTERVAL;
      low_limit_r     <= RST_LOW_LEVEL_LIMIT;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      sum_r       <= sum_nxt;
      phase_r     <= phase_nxt;
      chg_r       <= chg_nxt;
      low_r       <= low_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DETECT_BY_PIN:     detect_by_pin_r <= cfg_wdata[0];
          REG_VBUS_ACTIVE_LEVEL: vbus_level_r    <= cfg_wdata[0];
          REG_SAMPLE_INTERVAL:   interval_r      <= cfg_wdata[11:0];
          REG_LOW_LEVEL_LIMIT:   low_limit_r     <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
    bat_r      <= bat_nxt;
    chg_ev_r   <= chg_ev_nxt;
    low_ev_r   <= low_ev_nxt;
    taken_r    <= taken_nxt;
    avg_r      <= avg_nxt;
    band_r     <= band_nxt;
    rest_r     <= rest_nxt;
    below_r    <= below_nxt;
    above_r    <= above_nxt;
    out_data_r <= out_data_nxt;
  end

  bgma_ram #(
    .WIDTH  (SAMPLE_W),
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (SLOT_W)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (bat_r),
    .raddr (slot),
    .rdata (old_sample)
  );

  bgma_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .num      (sum_r),
    .den      (fill_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The fill count only grows until reset.
  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fill_r >= $past(fill_r)))
    else $error("window fill count went down");

  // A new result appears only from the delivery step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DELIVER))
    else $error("result raised outside delivery");

  // The low flag changes only with a full window.
  a_low_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.low_changed) |-> (fill_r == FULL_CNT))
    else $error("low flag changed before the window was full");

  // A division is started only after the sum update.
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> ($past(state_r) == S_UPDATE))
    else $error("divider started out of sequence");

endmodule

// ===== src/bgma_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bgma_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bgma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgma_div
// Restoring divider with an NUM_W-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgma_div #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  always_comb begin
    shifted  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
    fits     = (shifted >= {1'b0, den_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (shifted - {1'b0, den_r}) : shifted;
      quo_nxt = {quo_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
